>>> sv/kil_pkg.sv
// Shared types and constants for the keyword and integer lexer.
// Holds the request and token payload structs and the fixed keyword table.
// No dependencies; every other file imports this package.
`default_nettype none

package kil_pkg;

  localparam int NUM_KW   = 7;
  localparam int KW_SLOTS = 9;
  localparam int VAL_W    = 30;
  localparam int LEN_W    = 4;

  // Request kinds.
  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_END  = 1'b1;

  // Token classes.
  localparam logic CLASS_INT     = 1'b0;
  localparam logic CLASS_KEYWORD = 1'b1;

  // Keyword ids.
  localparam logic [2:0] KW_INTEGER   = 3'd0;
  localparam logic [2:0] KW_FLOATING  = 3'd1;
  localparam logic [2:0] KW_CHARACTER = 3'd2;
  localparam logic [2:0] KW_STRING    = 3'd3;
  localparam logic [2:0] KW_FUNCTION  = 3'd4;
  localparam logic [2:0] KW_RETURN    = 3'd5;
  localparam logic [2:0] KW_EXIT      = 3'd6;

  // Keyword text, right-justified: character i of a keyword of length L sits
  // in bits 8*(L-1-i) +: 8.
  localparam logic [0:NUM_KW-1][8*KW_SLOTS-1:0] KW_TEXT = '{
    72'("integer"), 72'("floating"), 72'("character"), 72'("string"),
    72'("function"), 72'("return"), 72'("exit")
  };
  localparam logic [0:NUM_KW-1][LEN_W-1:0] KW_LEN = '{
    4'd7, 4'd8, 4'd9, 4'd6, 4'd8, 4'd6, 4'd4
  };

  typedef struct packed {
    logic       kind;
    logic [7:0] char_code;
  } kil_item_t;

  typedef struct packed {
    logic             token_class;
    logic [2:0]       keyword_id;
    logic [VAL_W-1:0] literal_value;
    logic             too_many_digits;
  } kil_token_t;

  // Progress of a letter run through the keyword table.
  typedef struct packed {
    logic [NUM_KW-1:0] mask;
    logic [LEN_W-1:0]  length;
  } kil_word_t;

  // Largest number of the given count of decimal digits.
  function automatic logic [VAL_W-1:0] sat_max(input int digits);
    logic [VAL_W-1:0] v;
    v = '0;
    for (int i = 0; i < digits; i++) begin
      v = VAL_W'(v * 10 + 9);
    end
    return v;
  endfunction

endpackage

`default_nettype wire

>>> sv/kil_kw_match.sv
// Keyword matcher: narrows the set of live keywords by one letter and finds
// the keyword, if any, that a finished letter run spells. Uses kil_pkg.
`default_nettype none

module kil_kw_match #(
  parameter int MAX_WORD = 9
) (
  input  kil_pkg::kil_word_t base,
  input  logic [7:0]         letter,
  input  kil_pkg::kil_word_t cur,
  output kil_pkg::kil_word_t grown,
  output logic               found,
  output logic [2:0]         found_id
);
  import kil_pkg::*;

  function automatic logic [7:0] kw_char(input int k, input logic [LEN_W-1:0] idx);
    logic [7:0] c;
    c = '0;
    for (int i = 0; i < KW_SLOTS; i++) begin
      if (i < int'(KW_LEN[k]) && idx == LEN_W'(i)) begin
        c = KW_TEXT[k][8*(int'(KW_LEN[k]) - 1 - i) +: 8];
      end
    end
    return c;
  endfunction

  always_comb begin
    grown.mask = base.mask;
    if (base.length >= LEN_W'(MAX_WORD)) begin
      grown.mask = '0;
    end else begin
      for (int k = 0; k < NUM_KW; k++) begin
        if (base.length >= KW_LEN[k] || kw_char(k, base.length) != letter) begin
          grown.mask[k] = 1'b0;
        end
      end
    end
    grown.length = (base.length == '1) ? base.length : base.length + LEN_W'(1);
  end

  // The first live keyword whose length equals the run length wins.
  always_comb begin
    found    = 1'b0;
    found_id = KW_INTEGER;
    for (int k = NUM_KW - 1; k >= 0; k--) begin
      if (cur.mask[k] && KW_LEN[k] == cur.length) begin
        found    = 1'b1;
        found_id = 3'(k);
      end
    end
    if (cur.length > LEN_W'(MAX_WORD)) begin
      found = 1'b0;
    end
  end

endmodule

`default_nettype wire

>>> sv/kil_scan.sv
// Scanner state and per-byte step: tracks the current digit or letter run,
// updates it on each advanced request and forms the finished token.
// Uses kil_pkg and kil_kw_match.
`default_nettype none

module kil_scan #(
  parameter int MAX_WORD   = 9,
  parameter int MAX_DIGITS = 9
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               advance,
  input  kil_pkg::kil_item_t item,
  output logic               emit,
  output kil_pkg::kil_token_t token
);
  import kil_pkg::*;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_NUM  = 2'd1,
    MODE_WORD = 2'd2
  } mode_t;

  localparam logic [VAL_W-1:0] SAT_VALUE = sat_max(MAX_DIGITS);

  mode_t            scan_mode, scan_mode_next;
  kil_word_t        word, word_next;
  logic [VAL_W-1:0] acc_value, acc_value_next;
  logic [LEN_W-1:0] digit_count, digit_count_next;
  logic             overflow_seen, overflow_seen_next;

  logic             is_digit, is_letter, cont_num, cont_word;
  kil_word_t        word_base, word_grown;
  logic             kw_found;
  logic [2:0]       kw_id;
  logic [VAL_W-1:0] base_value;
  logic [LEN_W-1:0] base_count;
  logic             base_ovf;
  logic             fin_num, fin_word;

  assign is_digit  = item.char_code >= 8'h30 && item.char_code <= 8'h39;
  assign is_letter = (item.char_code >= 8'h41 && item.char_code <= 8'h5A) ||
                     (item.char_code >= 8'h61 && item.char_code <= 8'h7A);
  assign cont_num  = item.kind == KIND_CHAR && scan_mode == MODE_NUM && is_digit;
  assign cont_word = item.kind == KIND_CHAR && scan_mode == MODE_WORD && is_letter;

  // A new letter run starts from a fresh table.
  assign word_base.mask   = cont_word ? word.mask : '1;
  assign word_base.length = cont_word ? word.length : '0;

  kil_kw_match #(
    .MAX_WORD(MAX_WORD)
  ) u_kw_match (
    .base     (word_base),
    .letter   (item.char_code),
    .cur      (word),
    .grown    (word_grown),
    .found    (kw_found),
    .found_id (kw_id)
  );

  assign base_value = cont_num ? acc_value : '0;
  assign base_count = cont_num ? digit_count : '0;
  assign base_ovf   = cont_num ? overflow_seen : 1'b0;

  assign fin_num  = scan_mode == MODE_NUM;
  assign fin_word = scan_mode == MODE_WORD && kw_found;

  always_comb begin
    scan_mode_next     = MODE_IDLE;
    word_next          = '{mask: '1, length: '0};
    acc_value_next     = '0;
    digit_count_next   = '0;
    overflow_seen_next = 1'b0;
    emit               = 1'b0;
    if (item.kind == KIND_END) begin
      emit = fin_num || fin_word;
    end else if (is_digit) begin
      scan_mode_next = MODE_NUM;
      emit           = !cont_num && (fin_num || fin_word);
      if (base_count < LEN_W'(MAX_DIGITS)) begin
        acc_value_next     = (base_value << 3) + (base_value << 1) +
                             VAL_W'(item.char_code[3:0]);
        digit_count_next   = base_count + LEN_W'(1);
        overflow_seen_next = base_ovf;
      end else begin
        acc_value_next     = SAT_VALUE;
        digit_count_next   = base_count;
        overflow_seen_next = 1'b1;
      end
    end else if (is_letter) begin
      scan_mode_next = MODE_WORD;
      emit           = !cont_word && (fin_num || fin_word);
      word_next      = word_grown;
    end else begin
      emit = fin_num || fin_word;
    end
  end

  always_comb begin
    if (fin_num) begin
      token = '{token_class: CLASS_INT, keyword_id: KW_INTEGER,
                literal_value: acc_value, too_many_digits: overflow_seen};
    end else begin
      token = '{token_class: CLASS_KEYWORD, keyword_id: kw_id,
                literal_value: '0, too_many_digits: 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode     <= MODE_IDLE;
      word          <= '{mask: '1, length: '0};
      acc_value     <= '0;
      digit_count   <= '0;
      overflow_seen <= 1'b0;
    end else if (advance) begin
      scan_mode     <= scan_mode_next;
      word          <= word_next;
      acc_value     <= acc_value_next;
      digit_count   <= digit_count_next;
      overflow_seen <= overflow_seen_next;
    end
  end

endmodule

`default_nettype wire

>>> sv/keyword_and_integer_lexer_top.sv
// Keyword and integer lexer: a byte stream is grouped into number tokens
// and keyword tokens.
//
// Channels: the request channel (src_valid, src_ready, src_item) carries one
// byte or an end-of-input mark per request; the token channel (tok_valid,
// tok_ready, tok_data) carries at most one token per request. Both follow a
// valid/ready handshake and transfer when valid and ready are high together.
// A token is produced by the byte that ends its run (that byte may start the
// next run) or by end of input, which flushes a pending run.
// An accepted request is held in the input register, and the scan step writes
// its token into the token register when the step advances; a stall on the
// token channel can hold the request between the two. Throughput is one request
// per cycle unless the receiver stalls.
// A token waiting in the output register does not block the next request
// from entering the input register. When the receiver stalls, the scan step
// holds and src_ready falls once the input register is also full.
// Reset (rst, synchronous) empties both registers and returns the scanner to
// idle with no pending run.
// Uses kil_pkg, kil_scan and kil_kw_match.
`default_nettype none

module keyword_and_integer_lexer_top #(
  parameter int MAX_WORD   = 9,
  parameter int MAX_DIGITS = 9
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                src_valid,
  output logic                src_ready,
  input  kil_pkg::kil_item_t  src_item,
  output logic                tok_valid,
  input  logic                tok_ready,
  output kil_pkg::kil_token_t tok_data
);
  import kil_pkg::*;

  logic       stage_valid;
  kil_item_t  stage_item;
  logic       advance;
  logic       emit;
  kil_token_t token;

  assign advance   = stage_valid && (!tok_valid || tok_ready);
  assign src_ready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (src_valid && src_ready) begin
      stage_valid <= 1'b1;
    end else if (advance) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (src_valid && src_ready) begin
      stage_item <= src_item;
    end
  end

  kil_scan #(
    .MAX_WORD   (MAX_WORD),
    .MAX_DIGITS (MAX_DIGITS)
  ) u_scan (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (stage_item),
    .emit    (emit),
    .token   (token)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_valid <= 1'b0;
    end else if (advance) begin
      tok_valid <= emit;
    end else if (tok_ready) begin
      tok_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      tok_data <= token;
    end
  end

endmodule

`default_nettype wire

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for keyword_and_integer_lexer_top: a directed table, then random
// text built from keywords, digit runs, words and noise, checked against a behavioral lexer.
// Depends on kil_pkg and the lexer top level.

module testbench;
  import kil_pkg::*;

  localparam int LEX_MAX_WORD   = 9;
  localparam int LEX_MAX_DIGITS = 9;
  localparam int LEX_NUM_KW     = 7;
  localparam logic [VAL_W-1:0] DIGITS_CAP = VAL_W'(10 ** LEX_MAX_DIGITS - 1);
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam int RANDOM_ITEMS  = 700;
  localparam int REPORT_LIMIT  = 10;
  localparam kil_token_t NO_TOKEN = '0;

  typedef enum logic [1:0] {SCAN_IDLE, SCAN_NUM, SCAN_WORD} scan_mode_e;
  typedef enum logic [1:0] {ROW_PREDICT, ROW_NONE, ROW_TOKEN} row_check_e;

  typedef struct {
    kil_item_t  item;
    row_check_e how;
    kil_token_t tok;
  } stim_row_t;

  logic       clk;
  logic       rst = 1'b1;
  logic       src_valid = 1'b0;
  logic       src_ready;
  kil_item_t  src_item = '0;
  logic       tok_valid;
  logic       tok_ready = 1'b0;
  kil_token_t tok_data;

  string kw_spelling [LEX_NUM_KW] = '{"integer", "floating", "character", "string",
                                      "function", "return", "exit"};

  // Behavioral copy of the scanner state.
  scan_mode_e        lex_mode;
  logic [LEN_W-1:0]  lex_len;
  logic [NUM_KW-1:0] lex_alive;
  logic [VAL_W-1:0]  lex_value;
  logic [3:0]        lex_digits;
  logic              lex_overflow;

  kil_token_t expected_tokens [$];
  stim_row_t  stim_rows [$];
  int mismatches = 0;
  int random_sent = 0;
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;

  keyword_and_integer_lexer_top #(
    .MAX_WORD(LEX_MAX_WORD),
    .MAX_DIGITS(LEX_MAX_DIGITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .src_valid(src_valid),
    .src_ready(src_ready),
    .src_item(src_item),
    .tok_valid(tok_valid),
    .tok_ready(tok_ready),
    .tok_data(tok_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic bit is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic bit is_letter(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  task automatic lex_clear();
    lex_mode     = SCAN_IDLE;
    lex_len      = '0;
    lex_alive    = '1;
    lex_value    = '0;
    lex_digits   = '0;
    lex_overflow = 1'b0;
  endtask

  task automatic lex_close(output bit hit, output kil_token_t tok);
    hit = 1'b0;
    tok = NO_TOKEN;
    if (lex_mode == SCAN_NUM) begin
      hit = 1'b1;
      tok.token_class     = CLASS_INT;
      tok.literal_value   = lex_value;
      tok.too_many_digits = lex_overflow;
    end else if (lex_mode == SCAN_WORD && lex_len <= LEX_MAX_WORD) begin
      for (int k = 0; k < LEX_NUM_KW; k++) begin
        if (!hit && lex_alive[k] && kw_spelling[k].len() == lex_len) begin
          hit = 1'b1;
          tok.token_class = CLASS_KEYWORD;
          tok.keyword_id  = 3'(k);
        end
      end
    end
    lex_clear();
  endtask

  task automatic lex_add_digit(input logic [7:0] c);
    if (lex_digits < LEX_MAX_DIGITS) begin
      lex_value  = VAL_W'(lex_value * 10 + (c - CHAR_ZERO));
      lex_digits = lex_digits + 1;
    end else begin
      // Past the digit limit the value pins at all nines.
      lex_overflow = 1'b1;
      lex_value    = DIGITS_CAP;
    end
  endtask

  task automatic lex_add_letter(input logic [7:0] c);
    if (lex_len >= LEX_MAX_WORD) begin
      lex_alive = '0;
    end else begin
      for (int k = 0; k < LEX_NUM_KW; k++) begin
        if (lex_len >= kw_spelling[k].len() || kw_spelling[k][lex_len] != c) begin
          lex_alive[k] = 1'b0;
        end
      end
    end
    if (lex_len < 15) begin
      lex_len = lex_len + 1;
    end
  endtask

  task automatic lex_step(input kil_item_t it, output bit hit, output kil_token_t tok);
    logic [7:0] c;
    c   = it.char_code;
    hit = 1'b0;
    tok = NO_TOKEN;
    if (it.kind == KIND_END) begin
      lex_close(hit, tok);
    end else if (lex_mode == SCAN_NUM && is_digit(c)) begin
      lex_add_digit(c);
    end else if (lex_mode == SCAN_WORD && is_letter(c)) begin
      lex_add_letter(c);
    end else begin
      // The byte that ends a run may start the next one.
      if (lex_mode == SCAN_NUM || lex_mode == SCAN_WORD) begin
        lex_close(hit, tok);
      end else begin
        lex_clear();
      end
      if (is_digit(c)) begin
        lex_mode = SCAN_NUM;
        lex_add_digit(c);
      end else if (is_letter(c)) begin
        lex_mode = SCAN_WORD;
        lex_add_letter(c);
      end
    end
  endtask

  task automatic send_request(input kil_item_t it, input row_check_e how,
                              input kil_token_t typed);
    bit hit;
    kil_token_t tok;
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      src_valid <= 1'b0;
      @(posedge clk);
    end
    src_valid <= 1'b1;
    src_item  <= it;
    @(posedge clk);
    while (!src_ready) begin
      @(posedge clk);
    end
    lex_step(it, hit, tok);
    if (how == ROW_TOKEN) begin
      expected_tokens.push_back(typed);
    end else if (how == ROW_PREDICT && hit) begin
      expected_tokens.push_back(tok);
    end
  endtask

  task automatic send_char(input logic [7:0] c);
    kil_item_t it;
    it.kind      = KIND_CHAR;
    it.char_code = c;
    send_request(it, ROW_PREDICT, NO_TOKEN);
    random_sent++;
  endtask

  function automatic logic [7:0] random_letter();
    int r;
    r = $urandom_range(0, 51);
    return (r < 26) ? 8'(8'h41 + r) : 8'(8'h61 + r - 26);
  endfunction

  function automatic logic [7:0] random_separator();
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(0, 255));
    end while (is_digit(c) || is_letter(c));
    return c;
  endfunction

  // At most one random token, mostly well formed, then a separator, end of input or nothing.
  task automatic send_random_token();
    int pick, k, len, flip, mutate, extra;
    logic [7:0] c;
    kil_item_t it;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      k      = $urandom_range(0, LEX_NUM_KW - 1);
      len    = kw_spelling[k].len();
      mutate = $urandom_range(0, 9);
      flip   = (mutate == 7) ? $urandom_range(0, len - 1) : -1;
      if (mutate == 8) begin
        len = $urandom_range(1, len - 1);
      end
      extra = (mutate == 9) ? $urandom_range(1, 8) : 0;
      for (int i = 0; i < len; i++) begin
        c = kw_spelling[k][i];
        send_char((i == flip) ? (c ^ 8'h20) : c);
      end
      for (int i = 0; i < extra; i++) begin
        send_char(random_letter());
      end
    end else if (pick < 55) begin
      len = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 14) : $urandom_range(1, 9);
      for (int i = 0; i < len; i++) begin
        send_char(8'(CHAR_ZERO + $urandom_range(0, 9)));
      end
    end else if (pick < 70) begin
      len = $urandom_range(1, 18);
      for (int i = 0; i < len; i++) begin
        send_char(random_letter());
      end
    end else if (pick < 82) begin
      send_char(8'($urandom_range(0, 255)));
    end
    pick = $urandom_range(0, 99);
    if (pick < 65) begin
      send_char(random_separator());
    end else if (pick < 80) begin
      it.kind      = KIND_END;
      it.char_code = 8'($urandom_range(0, 255));
      send_request(it, ROW_PREDICT, NO_TOKEN);
      random_sent++;
    end
  endtask

  task automatic add_row(input logic kind, input logic [7:0] code, input row_check_e how,
                         input kil_token_t tok);
    stim_row_t row;
    row.item.kind      = kind;
    row.item.char_code = code;
    row.how            = how;
    row.tok            = tok;
    stim_rows.push_back(row);
  endtask

  always @(posedge clk) begin
    kil_token_t want;
    if (rst) begin
      tok_ready <= 1'b0;
    end else begin
      if (tok_valid && tok_ready) begin
        if (expected_tokens.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT) begin
            $display("Unexpected token: class %0d id %0d value %0d overflow %0d",
                     tok_data.token_class, tok_data.keyword_id, tok_data.literal_value,
                     tok_data.too_many_digits);
          end
        end else begin
          want = expected_tokens.pop_front();
          if (tok_data.token_class !== want.token_class ||
              tok_data.keyword_id !== want.keyword_id ||
              tok_data.literal_value !== want.literal_value ||
              tok_data.too_many_digits !== want.too_many_digits) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
              $display("Token mismatch: expected class %0d id %0d value %0d overflow %0d,",
                       want.token_class, want.keyword_id, want.literal_value,
                       want.too_many_digits);
              $display("                got      class %0d id %0d value %0d overflow %0d",
                       tok_data.token_class, tok_data.keyword_id, tok_data.literal_value,
                       tok_data.too_many_digits);
            end
          end
        end
      end
      tok_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end
  end

  initial begin
    lex_clear();

    // End of input while idle, then a keyword closed by a space.
    add_row(KIND_END, 8'hFF, ROW_NONE, NO_TOKEN);
    add_row(KIND_CHAR, "e", ROW_PREDICT, NO_TOKEN);
    add_row(KIND_CHAR, "x", ROW_PREDICT, NO_TOKEN);
    add_row(KIND_CHAR, "i", ROW_PREDICT, NO_TOKEN);
    add_row(KIND_CHAR, "t", ROW_PREDICT, NO_TOKEN);
    add_row(KIND_CHAR, " ", ROW_TOKEN, '{CLASS_KEYWORD, KW_EXIT, '0, 1'b0});
    // A letter ends a number and starts a word that matches nothing.
    add_row(KIND_CHAR, "0", ROW_PREDICT, NO_TOKEN);
    add_row(KIND_CHAR, "a", ROW_TOKEN, '{CLASS_INT, 3'd0, '0, 1'b0});
    add_row(KIND_END, 8'h00, ROW_NONE, NO_TOKEN);
    add_row(KIND_CHAR, 8'hFF, ROW_PREDICT, NO_TOKEN);
    add_row(KIND_CHAR, 8'h00, ROW_PREDICT, NO_TOKEN);
    // Ten nines: one past the digit limit saturates and flags the token.
    for (int i = 0; i < 10; i++) begin
      add_row(KIND_CHAR, "9", ROW_PREDICT, NO_TOKEN);
    end
    add_row(KIND_END, 8'h39, ROW_TOKEN, '{CLASS_INT, 3'd0, DIGITS_CAP, 1'b1});
    add_row(KIND_CHAR, "Z", ROW_PREDICT, NO_TOKEN);
    add_row(KIND_CHAR, "z", ROW_PREDICT, NO_TOKEN);
    add_row(KIND_END, 8'h41, ROW_NONE, NO_TOKEN);

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (stim_rows[i]) begin
      send_request(stim_rows[i].item, stim_rows[i].how, stim_rows[i].tok);
    end

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 57; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 57; end
        default: begin sender_idle_pct = 12; receiver_stall_pct = 12; end
      endcase
      while (random_sent < (ph + 1) * RANDOM_ITEMS / 4) begin
        send_random_token();
      end
    end
    src_valid <= 1'b0;

    while (expected_tokens.size() != 0) begin
      @(posedge clk);
    end
    repeat (8) @(posedge clk);

    if (mismatches == 0 && expected_tokens.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
